@@ design/tfc_pkg.sv @@
`default_nettype none

package tfc_pkg;

    // Top-level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CRC,
        S_CHECK,
        S_ARITH,
        S_FIN
    } t_state;

    // Arithmetic unit phases
    typedef enum logic [2:0] {
        A_IDLE,
        A_DIV,
        A_SQ,
        A_SQRT,
        A_CORD,
        A_MUL1,
        A_MUL2,
        A_DONE
    } t_aphase;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK  = 2'd0,
        STAT_CRC = 2'd1,
        STAT_RS  = 2'd2,
        STAT_OFF = 2'd3
    } t_status;

    // Configuration register indexes
    localparam logic [2:0] CFG_ENABLE = 3'd0;
    localparam logic [2:0] CFG_CPG    = 3'd1;
    localparam logic [2:0] CFG_GAUGE  = 3'd2;
    localparam logic [2:0] CFG_LIMIT  = 3'd3;
    localparam logic [2:0] CFG_NORMAL = 3'd4;

    localparam logic [7:0]  CRC_POLY    = 8'h1D;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_XOUT    = 8'hFF;
    localparam logic [16:0] Q16_ONE     = 17'h10000;
    localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
    localparam logic [18:0] LEVEL_MAX   = 19'd524287;
    localparam logic [6:0]  LEVEL_SCALE = 7'd100;
    localparam logic [36:0] ROUND_HALF  = 37'd32768;

    // Request to the arithmetic unit
    typedef struct packed {
        logic        start;
        logic [15:0] mag;
        logic [14:0] cpg;
        logic [11:0] gauge;
    } t_arith_req;

    // Response from the arithmetic unit
    typedef struct packed {
        logic        done;
        logic [18:0] mag;
    } t_arith_rsp;

    // One byte of CRC-8, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // round(atan(2^-i) * 65536)
    function automatic logic [15:0] atan_q16(input logic [3:0] i);
        logic [15:0] a;
        case (i)
            4'd0:    a = 16'd51472;
            4'd1:    a = 16'd30386;
            4'd2:    a = 16'd16055;
            4'd3:    a = 16'd8150;
            4'd4:    a = 16'd4091;
            4'd5:    a = 16'd2047;
            4'd6:    a = 16'd1024;
            4'd7:    a = 16'd512;
            4'd8:    a = 16'd256;
            4'd9:    a = 16'd128;
            4'd10:   a = 16'd64;
            4'd11:   a = 16'd32;
            4'd12:   a = 16'd16;
            4'd13:   a = 16'd8;
            4'd14:   a = 16'd4;
            default: a = 16'd2;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

@@ design/tilt_frame_check_and_cross_level_top.sv @@
// Tilt frame checker and cross-level converter.
//
// Input channel: i_in_valid / o_in_stall carry one 32-bit sensor frame
// (i_rx_frame) per item. Output channel: o_out_valid / i_out_stall carry
// one result item: cross level in signed 0.01 mm, status, return-status
// code, health flag and the consecutive CRC error count.
// Configuration: write i_cfg_data into register i_cfg_index while
// i_cfg_we is high; write only while the block is idle.
//
// A disabled block sends an item straight to its final state. Otherwise the
// CRC runs over the upper three bytes, then the check; a frame rejected
// on CRC or return status then goes to its final state. A good frame passes
// through the shared arithmetic unit: 16 divide steps (skipped when the
// sample is zero or at full scale), 17 square root steps, 16 CORDIC steps
// and the two multiplies. One item is in flight at a time; the next item is
// taken the cycle after the result is loaded into the output register.
// Reset restores register defaults (disabled, 6000 counts/g, 1435 mm,
// limit 3, normal code 1) and clears the error run, health and last level.
// A stalled result holds in the output register; a finished item waits in
// its final state until the output register is free.
`default_nettype none

module tilt_frame_check_and_cross_level_top
    import tfc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire         [31:0] i_rx_frame,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic signed [19:0] o_cross_level,
    output logic        [1:0]  o_status,
    output logic        [1:0]  o_rs_code,
    output logic               o_healthy_out,
    output logic        [7:0]  o_crc_errors_out,
    input  wire                i_cfg_we,
    input  wire         [2:0]  i_cfg_index,
    input  wire         [14:0] i_cfg_data
);

    // configuration
    logic        r_enable;
    logic [14:0] r_cpg;
    logic [11:0] r_gauge;
    logic [7:0]  r_limit;
    logic [1:0]  r_normal;

    // sequencer and item context
    t_state      r_state, n_state;
    logic [31:0] r_frame, n_frame;
    logic [7:0]  r_crc, n_crc;
    logic [1:0]  r_byte, n_byte;
    t_status     r_stat, n_stat;
    logic signed [19:0] r_level, n_level;

    // persistent state
    logic [7:0]  r_run, n_run;
    logic        r_healthy, n_healthy;
    logic signed [19:0] r_last, n_last;

    // output register
    logic        r_out_valid, n_out_valid;
    logic signed [19:0] r_o_level, n_o_level;
    logic [1:0]  r_o_status, n_o_status;
    logic [1:0]  r_o_rs, n_o_rs;
    logic        r_o_healthy, n_o_healthy;
    logic [7:0]  r_o_run, n_o_run;

    logic        w_accept;
    logic        w_load;
    logic [7:0]  w_byte;
    logic [15:0] w_sample;
    logic [7:0]  w_run_inc;
    t_arith_req  w_req;
    t_arith_rsp  w_rsp;

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_load   = (r_state == S_FIN) && (!r_out_valid || !i_out_stall);
    assign w_sample = r_frame[23:8];
    assign w_run_inc = (r_run != 8'hFF) ? (r_run + 8'd1) : r_run;

    // pick the CRC byte, top byte first
    always_comb begin
        case (r_byte)
            2'd0:    w_byte = r_frame[31:24];
            2'd1:    w_byte = r_frame[23:16];
            default: w_byte = r_frame[15:8];
        endcase
    end

    assign w_req.mag   = w_sample[15] ? (~w_sample + 16'd1) : w_sample;
    assign w_req.cpg   = r_cpg;
    assign w_req.gauge = r_gauge;
    assign w_req.start = (r_state == S_CHECK) && ((r_crc ^ CRC_XOUT) == r_frame[7:0])
                         && (r_frame[25:24] == r_normal);

    tfc_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        n_state     = r_state;
        n_frame     = r_frame;
        n_crc       = r_crc;
        n_byte      = r_byte;
        n_stat      = r_stat;
        n_level     = r_level;
        n_run       = r_run;
        n_healthy   = r_healthy;
        n_last      = r_last;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_level   = r_o_level;
        n_o_status  = r_o_status;
        n_o_rs      = r_o_rs;
        n_o_healthy = r_o_healthy;
        n_o_run     = r_o_run;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_frame = i_rx_frame;
                    if (!r_enable) begin
                        n_stat  = STAT_OFF;
                        n_state = S_FIN;
                    end else begin
                        n_crc   = CRC_INIT;
                        n_byte  = '0;
                        n_state = S_CRC;
                    end
                end
            end
            S_CRC: begin
                // advance one byte per cycle
                n_crc  = crc8_byte(r_crc, w_byte);
                n_byte = r_byte + 2'd1;
                if (r_byte == 2'd2) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if ((r_crc ^ CRC_XOUT) != r_frame[7:0]) begin
                    n_stat  = STAT_CRC;
                    n_state = S_FIN;
                end else if (r_frame[25:24] != r_normal) begin
                    n_stat  = STAT_RS;
                    n_state = S_FIN;
                end else begin
                    n_state = S_ARITH;
                end
            end
            S_ARITH: begin
                if (w_rsp.done) begin
                    n_level = w_sample[15] ? -signed'({1'b0, w_rsp.mag})
                                           : signed'({1'b0, w_rsp.mag});
                    n_stat  = STAT_OK;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold until the output register is free
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_o_status  = r_stat;
                    n_o_level   = r_last;
                    n_o_rs      = r_frame[25:24];
                    n_o_healthy = r_healthy;
                    n_o_run     = r_run;
                    case (r_stat)
                        STAT_OK: begin
                            n_run       = '0;
                            n_healthy   = 1'b1;
                            n_last      = r_level;
                            n_o_level   = r_level;
                            n_o_healthy = 1'b1;
                            n_o_run     = '0;
                        end
                        STAT_CRC: begin
                            n_run   = w_run_inc;
                            n_o_run = w_run_inc;
                            n_o_rs  = '0;
                            if (w_run_inc >= r_limit) begin
                                n_healthy   = 1'b0;
                                n_o_healthy = 1'b0;
                            end
                        end
                        STAT_RS: begin
                            n_run       = '0;
                            n_healthy   = 1'b0;
                            n_o_healthy = 1'b0;
                            n_o_run     = '0;
                        end
                        default: begin
                            n_o_rs = '0;
                        end
                    endcase
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_byte      <= '0;
            r_stat      <= STAT_OK;
            r_run       <= '0;
            r_healthy   <= 1'b0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_byte      <= n_byte;
            r_stat      <= n_stat;
            r_run       <= n_run;
            r_healthy   <= n_healthy;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frame     <= n_frame;
        r_crc       <= n_crc;
        r_level     <= n_level;
        r_o_level   <= n_o_level;
        r_o_status  <= n_o_status;
        r_o_rs      <= n_o_rs;
        r_o_healthy <= n_o_healthy;
        r_o_run     <= n_o_run;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_cpg    <= 15'd6000;
            r_gauge  <= 12'd1435;
            r_limit  <= 8'd3;
            r_normal <= 2'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_ENABLE: r_enable <= i_cfg_data[0];
                CFG_CPG:    r_cpg    <= i_cfg_data;
                CFG_GAUGE:  r_gauge  <= i_cfg_data[11:0];
                CFG_LIMIT:  r_limit  <= i_cfg_data[7:0];
                CFG_NORMAL: r_normal <= i_cfg_data[1:0];
                default: begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_cross_level    = r_o_level;
    assign o_status         = r_o_status;
    assign o_rs_code        = r_o_rs;
    assign o_healthy_out    = r_o_healthy;
    assign o_crc_errors_out = r_o_run;

endmodule

`default_nettype wire

@@ design/tfc_arith.sv @@
`default_nettype none

// Level magnitude from a sample magnitude: ratio by restoring division,
// cosine by bit-pair square root, angle by CORDIC vectoring, then scaling.
// One shared add/subtract unit carries the divide, root and CORDIC y path.
module tfc_arith
    import tfc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  t_arith_req i_req,
    output t_arith_rsp o_rsp
);

    t_aphase r_phase, n_phase;
    logic [4:0]  r_cnt, n_cnt;
    logic [14:0] r_rem, n_rem;
    logic [16:0] r_r, n_r;
    logic [32:0] r_v, n_v;
    logic [32:0] r_res, n_res;
    logic [32:0] r_bit, n_bit;
    logic signed [19:0] r_x, n_x;
    logic signed [19:0] r_y, n_y;
    logic signed [19:0] r_z, n_z;
    logic [28:0] r_p1, n_p1;
    logic [35:0] r_p2, n_p2;

    // shared unit
    logic signed [34:0] w_sa, w_sb, w_sum;
    logic               w_sub, w_ge;

    logic [33:0]        w_trial;
    logic [33:0]        w_sq;
    logic signed [19:0] w_xsh, w_ysh, w_xs, w_zs;
    logic               w_ypos;
    logic [15:0]        w_atan;
    logic [16:0]        w_zc;
    logic [36:0]        w_round;

    assign w_trial = {1'b0, r_res} + {1'b0, r_bit};
    assign w_sq    = 34'(r_r) * 34'(r_r);
    assign w_xsh   = r_x >>> r_cnt[3:0];
    assign w_ysh   = r_y >>> r_cnt[3:0];
    assign w_ypos  = !r_y[19] && (r_y != 20'sd0);
    assign w_atan  = atan_q16(r_cnt[3:0]);
    assign w_xs    = w_ypos ? (r_x + w_ysh) : (r_x - w_ysh);
    assign w_zs    = w_ypos ? (r_z + signed'({4'b0, w_atan})) : (r_z - signed'({4'b0, w_atan}));

    always_comb begin
        case (r_phase)
            A_DIV: begin
                w_sa  = signed'({19'b0, r_rem, 1'b0});
                w_sb  = signed'({20'b0, i_req.cpg});
                w_sub = 1'b1;
            end
            A_SQRT: begin
                w_sa  = signed'({2'b0, r_v});
                w_sb  = signed'({1'b0, w_trial});
                w_sub = 1'b1;
            end
            A_CORD: begin
                w_sa  = 35'(r_y);
                w_sb  = 35'(w_xsh);
                w_sub = w_ypos;
            end
            default: begin
                w_sa  = '0;
                w_sb  = '0;
                w_sub = 1'b0;
            end
        endcase
        w_sum = w_sub ? (w_sa - w_sb) : (w_sa + w_sb);
        w_ge  = !w_sum[34];
    end

    always_comb begin
        if (r_z[19]) begin
            w_zc = '0;
        end else if (r_z[18:0] > {2'b0, HALF_PI_Q16}) begin
            w_zc = HALF_PI_Q16;
        end else begin
            w_zc = r_z[16:0];
        end
    end

    assign w_round    = {1'b0, r_p2} + ROUND_HALF;
    assign o_rsp.done = (r_phase == A_DONE);
    assign o_rsp.mag  = (w_round[36:16] > {2'b0, LEVEL_MAX}) ? LEVEL_MAX : w_round[34:16];

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_r     = r_r;
        n_v     = r_v;
        n_res   = r_res;
        n_bit   = r_bit;
        n_x     = r_x;
        n_y     = r_y;
        n_z     = r_z;
        n_p1    = r_p1;
        n_p2    = r_p2;
        case (r_phase)
            A_IDLE: begin
                if (i_req.start) begin
                    n_cnt = '0;
                    if (i_req.mag == 16'd0) begin
                        n_r     = '0;
                        n_phase = A_SQ;
                    end else if (i_req.mag >= {1'b0, i_req.cpg}) begin
                        n_r     = Q16_ONE;
                        n_phase = A_SQ;
                    end else begin
                        n_rem   = i_req.mag[14:0];
                        n_r     = '0;
                        n_phase = A_DIV;
                    end
                end
            end
            A_DIV: begin
                // one quotient bit per cycle
                if (w_ge) begin
                    n_rem = w_sum[14:0];
                end else begin
                    n_rem = {r_rem[13:0], 1'b0};
                end
                n_r   = {r_r[15:0], w_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_phase = A_SQ;
                end
            end
            A_SQ: begin
                n_v     = 33'((34'h1_0000_0000) - w_sq);
                n_res   = '0;
                n_bit   = 33'h1_0000_0000;
                n_cnt   = '0;
                n_phase = A_SQRT;
            end
            A_SQRT: begin
                // one root bit per cycle
                if (w_ge) begin
                    n_v   = w_sum[32:0];
                    n_res = (r_res >> 1) + r_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                n_bit = r_bit >> 2;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd16) begin
                    n_x     = signed'({3'b0, n_res[16:0]});
                    n_y     = signed'({3'b0, r_r});
                    n_z     = '0;
                    n_cnt   = '0;
                    n_phase = A_CORD;
                end
            end
            A_CORD: begin
                n_x   = w_xs;
                n_y   = w_sum[19:0];
                n_z   = w_zs;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) begin
                    n_phase = A_MUL1;
                end
            end
            A_MUL1: begin
                n_p1    = 29'(w_zc) * 29'(i_req.gauge);
                n_phase = A_MUL2;
            end
            A_MUL2: begin
                n_p2    = 36'(r_p1) * 36'(LEVEL_SCALE);
                n_phase = A_DONE;
            end
            A_DONE: begin
                n_phase = A_IDLE;
            end
            default: begin
                n_phase = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= A_IDLE;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_r   <= n_r;
        r_v   <= n_v;
        r_res <= n_res;
        r_bit <= n_bit;
        r_x   <= n_x;
        r_y   <= n_y;
        r_z   <= n_z;
        r_p1  <= n_p1;
        r_p2  <= n_p2;
    end

endmodule

`default_nettype wire

@@ design/tfc_checker.sv @@
`default_nettype none

module tfc_checker
    import tfc_pkg::*;
(
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               i_in_valid,
    input wire               o_in_stall,
    input wire        [31:0] i_rx_frame,
    input wire               o_out_valid,
    input wire               i_out_stall,
    input wire signed [19:0] o_cross_level,
    input wire        [1:0]  o_status,
    input wire        [1:0]  o_rs_code,
    input wire               o_healthy_out,
    input wire        [7:0]  o_crc_errors_out,
    input wire               i_cfg_we,
    input wire        [2:0]  i_cfg_index,
    input wire        [14:0] i_cfg_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // busy right after taking an item
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("item taken while still idle");

    a_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_OK) |-> o_healthy_out && (o_crc_errors_out == 8'd0))
        else $error("good item without health or with error run");

    a_rs_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_RS) |-> !o_healthy_out && (o_crc_errors_out == 8'd0))
        else $error("status reject kept health or error run");

    a_rs_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_status == STAT_CRC) || (o_status == STAT_OFF)) |-> (o_rs_code == 2'd0))
        else $error("return status shown on rejected frame");

endmodule

bind tilt_frame_check_and_cross_level_top tfc_checker u_tfc_checker (.*);

`default_nettype wire

@@ dv/tilt_frame_check_and_cross_level_checker.sv @@
`timescale 1ns / 100ps

module tilt_frame_check_and_cross_level_checker
    import tfc_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    input  wire                i_in_stall,
    input  wire         [31:0] i_rx_frame,
    input  wire                i_out_valid,
    input  wire                i_out_stall,
    input  wire  signed [19:0] i_cross_level,
    input  wire         [1:0]  i_status,
    input  wire         [1:0]  i_rs_code,
    input  wire                i_healthy_out,
    input  wire         [7:0]  i_crc_errors_out,
    input  wire                i_cfg_we,
    input  wire         [2:0]  i_cfg_index,
    input  wire         [14:0] i_cfg_data,
    output logic        [31:0] o_mismatches,
    output logic        [31:0] o_pending
);

    // round(atan(2^-i) * 2^16), step 0 in the low bits
    localparam logic [255:0] ATAN_STEPS = {
        16'd2, 16'd4, 16'd8, 16'd16, 16'd32, 16'd64, 16'd128, 16'd256,
        16'd512, 16'd1024, 16'd2047, 16'd4091, 16'd8150, 16'd16055, 16'd30386, 16'd51472
    };
    localparam longint ONE_Q16      = 65536;
    localparam longint QUARTER_TURN = 102944;
    localparam longint LEVEL_TOP    = 524287;
    localparam int     REPORT_LINES = 100;

    typedef struct packed {
        logic signed [19:0] level;
        t_status            status;
        logic        [1:0]  rs;
        logic               healthy;
        logic        [7:0]  crc_run;
    } t_tilt_reading;

    t_tilt_reading expected_readings[$];
    t_tilt_reading due;
    int            mismatches = 0;

    // Register shadows
    logic               enabled;
    logic        [14:0] sensitivity;
    logic        [11:0] rail_gauge;
    logic        [7:0]  crc_trip;
    logic        [1:0]  normal_code;

    // Block state shadows
    logic        [7:0]  bad_crc_streak;
    logic               link_healthy;
    logic signed [19:0] held_level;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("[%0t] tilt check: %s got %0d, want %0d", $time, what, got, want);
    endtask

    function automatic logic [7:0] crc_of(input logic [31:0] frame);
        logic [7:0] crc;
        int         k;
        crc = CRC_INIT;
        for (k = 31; k >= 8; k--)
            crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ frame[k]) ? CRC_POLY : 8'h00);
        return crc ^ CRC_XOUT;
    endfunction

    function automatic longint root_q16(input longint v);
        longint res;
        longint trial;
        int     b;
        res = 0;
        for (b = 16; b >= 0; b--) begin
            trial = res | (longint'(1) << b);
            if (trial * trial <= v)
                res = trial;
        end
        return res;
    endfunction

    // Arcsine of sample/sensitivity by CORDIC vectoring, scaled by the gauge
    function automatic logic signed [19:0] level_of(input logic signed [15:0] raw);
        longint             mag, ratio, x, y, z, nx, ny, q;
        int                 i;
        logic signed [19:0] lv;
        mag = (raw < 0) ? -longint'(raw) : longint'(raw);
        if (sensitivity == '0)
            ratio = (mag != 0) ? ONE_Q16 : 0;
        else
            ratio = (mag << 16) / longint'(sensitivity);
        if (ratio > ONE_Q16)
            ratio = ONE_Q16;
        x = root_q16((longint'(1) << 32) - ratio * ratio);
        y = ratio;
        z = 0;
        for (i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z  = z + longint'(ATAN_STEPS[i*16 +: 16]);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z  = z - longint'(ATAN_STEPS[i*16 +: 16]);
            end
            x = nx;
            y = ny;
        end
        if (z < 0)
            z = 0;
        if (z > QUARTER_TURN)
            z = QUARTER_TURN;
        q = (z * longint'(rail_gauge) * 100 + 32768) >>> 16;
        if (q > LEVEL_TOP)
            q = LEVEL_TOP;
        lv = q[19:0];
        return (raw < 0) ? -lv : lv;
    endfunction

    task automatic predict_reading(input logic [31:0] frame, output t_tilt_reading r);
        r.level = held_level;
        r.rs    = 2'd0;
        if (!enabled) begin
            r.status = STAT_OFF;
        end else if (crc_of(frame) != frame[7:0]) begin
            if (bad_crc_streak != 8'hFF)
                bad_crc_streak = bad_crc_streak + 8'd1;
            if (bad_crc_streak >= crc_trip)
                link_healthy = 1'b0;
            r.status = STAT_CRC;
        end else begin
            bad_crc_streak = '0;
            r.rs = frame[25:24];
            if (r.rs != normal_code) begin
                link_healthy = 1'b0;
                r.status     = STAT_RS;
            end else begin
                link_healthy = 1'b1;
                held_level   = level_of(frame[23:8]);
                r.level      = held_level;
                r.status     = STAT_OK;
            end
        end
        r.healthy = link_healthy;
        r.crc_run = bad_crc_streak;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            enabled        = 1'b0;
            sensitivity    = 15'd6000;
            rail_gauge     = 12'd1435;
            crc_trip       = 8'd3;
            normal_code    = 2'd1;
            bad_crc_streak = '0;
            link_healthy   = 1'b0;
            held_level     = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ENABLE: enabled     = i_cfg_data[0];
                    CFG_CPG:    sensitivity = i_cfg_data[14:0];
                    CFG_GAUGE:  rail_gauge  = i_cfg_data[11:0];
                    CFG_LIMIT:  crc_trip    = i_cfg_data[7:0];
                    CFG_NORMAL: normal_code = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with no item waiting, level",
                                    longint'(i_cross_level), 0);
                end else begin
                    due = expected_readings.pop_front();
                    if (i_cross_level != due.level)
                        report_mismatch("cross_level", longint'(i_cross_level),
                                        longint'(due.level));
                    if (i_status != due.status)
                        report_mismatch("status", longint'(i_status), longint'(due.status));
                    if (i_rs_code != due.rs)
                        report_mismatch("rs_code", longint'(i_rs_code), longint'(due.rs));
                    if (i_healthy_out != due.healthy)
                        report_mismatch("healthy_out", longint'(i_healthy_out),
                                        longint'(due.healthy));
                    if (i_crc_errors_out != due.crc_run)
                        report_mismatch("crc_errors_out", longint'(i_crc_errors_out),
                                        longint'(due.crc_run));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_reading(i_rx_frame, due);
                expected_readings.push_back(due);
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= expected_readings.size();
    end

endmodule

@@ dv/tilt_frame_check_and_cross_level_top_tb.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the tilt frame checker. The checker instance
// watches both channels and the register port, predicts every result and
// counts mismatches; this module only drives items, registers and stalls.
module tilt_frame_check_and_cross_level_top_tb
    import tfc_pkg::*;
();

    // Watchdog limit, well above the slowest correct run
    localparam int CYCLE_LIMIT   = 500000;
    // Longest single-item latency with margin, used for the final quiet period
    localparam int DRAIN_CYCLES  = 80;
    localparam int SEGMENT_ITEMS = 35;
    // Enough back-to-back CRC failures to saturate the error run count
    localparam int STREAK_ITEMS  = 260;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic        [31:0] i_rx_frame  = '0;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic        [2:0]  i_cfg_index = '0;
    logic        [14:0] i_cfg_data  = '0;

    wire                o_in_stall;
    wire                o_out_valid;
    wire signed  [19:0] o_cross_level;
    wire         [1:0]  o_status;
    wire         [1:0]  o_rs_code;
    wire                o_healthy_out;
    wire         [7:0]  o_crc_errors_out;

    wire         [31:0] mismatches;
    wire         [31:0] pending;

    int                 send_idle_pct = 0;
    int                 recv_idle_pct = 0;
    int                 cycle_count   = 0;

    // Stimulus-side copy of the settings that shape well-formed items
    logic        [14:0] cur_cpg    = 15'd6000;
    logic        [1:0]  cur_normal = 2'd1;

    tilt_frame_check_and_cross_level_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_frame       (i_rx_frame),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_cross_level    (o_cross_level),
        .o_status         (o_status),
        .o_rs_code        (o_rs_code),
        .o_healthy_out    (o_healthy_out),
        .o_crc_errors_out (o_crc_errors_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    tilt_frame_check_and_cross_level_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_stall       (o_in_stall),
        .i_rx_frame       (i_rx_frame),
        .i_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .i_cross_level    (o_cross_level),
        .i_status         (o_status),
        .i_rs_code        (o_rs_code),
        .i_healthy_out    (o_healthy_out),
        .i_crc_errors_out (o_crc_errors_out),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending)
    );

    always #10 i_clk = ~i_clk;

    // Receiver back-pressure: redraw the stall every cycle
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Watchdog: end the run if the stimulus or the drain hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("** tilt_frame_check_and_cross_level_top: FAILED **");
        $finish;
    end

    // Switch idle rates at an edge so the stall process sees a clean update
    task automatic set_idling(input int sender, input int receiver);
        send_idle_pct <= sender;
        recv_idle_pct <= receiver;
    endtask

    // Drop valid and hold until every predicted result has been taken
    task automatic await_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // One register write; starts on a fresh edge so back-to-back writes never
    // raise and lower the enable in the same step
    task automatic write_register(input logic [2:0] index, input logic [14:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Drain, then write every register
    task automatic apply_setup(input logic en, input logic [14:0] cpg,
                               input logic [11:0] gauge, input logic [7:0] limit,
                               input logic [1:0] normal);
        await_idle();
        write_register(CFG_ENABLE, {14'd0, en});
        write_register(CFG_CPG, cpg);
        write_register(CFG_GAUGE, {3'd0, gauge});
        write_register(CFG_LIMIT, {7'd0, limit});
        write_register(CFG_NORMAL, {13'd0, normal});
        cur_cpg    = cpg;
        cur_normal = normal;
    endtask

    // Random settings for a random segment; disable now and then
    task automatic random_setup();
        logic [14:0] cpg;
        case ($urandom_range(0, 3))
            0:       cpg = 15'($urandom_range(1, 200));
            1:       cpg = 15'($urandom_range(1, 32767));
            default: cpg = 15'($urandom_range(2000, 16000));
        endcase
        apply_setup($urandom_range(0, 9) != 0, cpg, 12'($urandom_range(1, 3000)),
                    8'($urandom_range(1, 8)), 2'($urandom_range(0, 3)));
    endtask

    // Present one item after a random gap, hold it until accepted
    task automatic send_frame(input logic [31:0] frame);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_frame <= frame;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Build a frame with a correct check byte over the upper three bytes
    function automatic logic [31:0] sealed_frame(input logic [5:0] spare,
                                                 input logic [1:0] rs,
                                                 input logic [15:0] raw);
        logic [23:0] payload;
        logic [7:0]  crc;
        int          k;
        payload = {spare, rs, raw};
        crc = CRC_INIT;
        for (k = 23; k >= 0; k--)
            crc = {crc[6:0], 1'b0} ^ ((crc[7] ^ payload[k]) ? CRC_POLY : 8'h00);
        return {payload, crc ^ CRC_XOUT};
    endfunction

    // Sample mix: anywhere, near full scale of the sensitivity, corners, tiny
    function automatic logic [15:0] pick_raw(input int cpg);
        logic [15:0] s;
        int          span;
        case ($urandom_range(0, 3))
            0: s = 16'($urandom);
            1: begin
                span = cpg + cpg / 8;
                if (span > 32767)
                    span = 32767;
                s = 16'($urandom_range(0, span));
                if ($urandom_range(0, 1))
                    s = -s;
            end
            2: begin
                case ($urandom_range(0, 4))
                    0:       s = 16'h0000;
                    1:       s = 16'h0001;
                    2:       s = 16'hFFFF;
                    3:       s = 16'h7FFF;
                    default: s = 16'h8000;
                endcase
            end
            default: begin
                s = 16'($urandom_range(0, 255));
                if ($urandom_range(0, 1))
                    s = -s;
            end
        endcase
        return s;
    endfunction

    // Mostly well-formed frames, then corrupted check bytes, then pure noise
    task automatic send_random_item();
        int          pick;
        logic [1:0]  rs;
        logic [31:0] frame;
        pick  = $urandom_range(0, 99);
        rs    = ($urandom_range(0, 9) < 8) ? cur_normal : 2'($urandom_range(0, 3));
        frame = sealed_frame(6'($urandom_range(0, 63)), rs, pick_raw(int'(cur_cpg)));
        if (pick >= 85)
            frame = $urandom;
        else if (pick >= 60)
            frame[7:0] = frame[7:0] ^ 8'($urandom_range(1, 255));
        send_frame(frame);
    endtask

    task automatic run_segment();
        int n;
        for (n = 0; n < SEGMENT_ITEMS; n++) begin
            // Occasionally starve the block until it has fully drained
            if ($urandom_range(0, 39) == 0)
                await_idle();
            send_random_item();
        end
    endtask

    initial begin
        int         n;
        logic [1:0] rs;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_idling(36, 84);

        // Still disabled out of reset: every frame is rejected
        send_frame(sealed_frame(6'h00, 2'd1, 16'd1000));

        // Default scaling, enabled
        apply_setup(1'b1, 15'd6000, 12'd1435, 8'd3, 2'd1);
        send_frame(sealed_frame(6'h15, 2'd1, 16'h0000));
        send_frame(sealed_frame(6'h15, 2'd1, 16'h0001));
        send_frame(sealed_frame(6'h15, 2'd1, 16'hFFFF));
        send_frame(sealed_frame(6'h15, 2'd1, 16'd6000));
        send_frame(sealed_frame(6'h15, 2'd1, -16'sd6000));
        send_frame(sealed_frame(6'h15, 2'd1, 16'd3000));
        send_frame(sealed_frame(6'h15, 2'd1, 16'h7FFF));
        send_frame(sealed_frame(6'h15, 2'd1, 16'h8000));

        // Return status other than the normal code
        for (rs = 2'd0; rs != 2'd3; rs++)
            if (rs != 2'd1)
                send_frame(sealed_frame(6'h2A, rs, 16'd1234));
        send_frame(sealed_frame(6'h2A, 2'd3, 16'd1234));

        // Run of check byte failures: health drops once the run hits the limit
        for (n = 0; n < 4; n++)
            send_frame(sealed_frame(6'h01, 2'd1, 16'd500) ^ (32'h1 << n));
        send_frame(32'h0000_0000);
        send_frame(32'hFFFF_FFFF);
        send_frame(sealed_frame(6'h3F, 2'd1, 16'h8001));

        // Zero sensitivity, gauge past its range, zero error limit
        apply_setup(1'b1, 15'd0, 12'd4095, 8'd0, 2'd3);
        send_frame(sealed_frame(6'h0F, 2'd3, 16'h0000));
        send_frame(sealed_frame(6'h0F, 2'd3, 16'd5));
        send_frame(sealed_frame(6'h0F, 2'd3, 16'h8000));
        send_frame(sealed_frame(6'h0F, 2'd3, 16'h7FFF) ^ 32'h80);
        send_frame(sealed_frame(6'h30, 2'd3, 16'h7FFF));

        // Disabled again: last good level comes back
        apply_setup(1'b0, 15'd6000, 12'd1435, 8'd3, 2'd1);
        send_frame(sealed_frame(6'h00, 2'd1, 16'd777));

        // Random segments: extreme settings first, then random ones
        apply_setup(1'b1, 15'd1, 12'd1, 8'd1, 2'd0);
        run_segment();
        apply_setup(1'b1, 15'd32767, 12'd3000, 8'd255, 2'd2);
        run_segment();

        set_idling(84, 36);
        random_setup();
        run_segment();
        random_setup();
        run_segment();

        set_idling(0, 0);
        random_setup();
        run_segment();
        random_setup();
        run_segment();

        // Long failure streak to saturate the error run count, then recover
        apply_setup(1'b1, 15'd6000, 12'd1435, 8'd255, 2'd1);
        for (n = 0; n < STREAK_ITEMS; n++)
            send_frame(sealed_frame(6'($urandom_range(0, 63)), 2'd1, 16'($urandom))
                       ^ $urandom_range(1, 255));
        send_frame(sealed_frame(6'($urandom_range(0, 63)), 2'd1, pick_raw(int'(cur_cpg))));
        send_frame(sealed_frame(6'($urandom_range(0, 63)), 2'd1, pick_raw(int'(cur_cpg))));

        // Drain, then stay quiet long enough to catch a stray result
        await_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0 && pending == 0)
            $display("** tilt_frame_check_and_cross_level_top: PASSED **");
        else
            $display("** tilt_frame_check_and_cross_level_top: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
design/tfc_pkg.sv
design/tfc_arith.sv
design/tilt_frame_check_and_cross_level_top.sv
design/tfc_checker.sv
dv/tilt_frame_check_and_cross_level_checker.sv
dv/tilt_frame_check_and_cross_level_top_tb.sv
